// ===== hw/rtl/vsos_pkg.sv =====
// shared types and constants for the vital sign outlier smoother
package vsos_pkg;

    localparam int HIST_DEPTH   = 16;
    localparam int VAL_W        = 10;
    localparam int RAW_W        = 11;
    localparam int MARGIN_W     = 8;
    localparam int INV_W        = 2;
    localparam int PERIOD_W     = 4;
    localparam int PHASE_W      = 3;
    localparam int FILL_W       = 5;
    localparam int RUN_W        = 3;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 10;
    localparam int S_TDATA_W    = 24;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 24;
    localparam int M_TUSER_W    = 1;

    localparam logic [RUN_W-1:0]    RUN_FULL   = RUN_W'(4);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(8);

    localparam logic [VAL_W-1:0] HR_LOW_RST     = VAL_W'(60);
    localparam logic [VAL_W-1:0] HR_HIGH_RST    = VAL_W'(150);
    localparam logic [VAL_W-1:0] SPO2_LOW_RST   = VAL_W'(80);
    localparam logic [MARGIN_W-1:0] MARGIN_RST  = MARGIN_W'(10);
    localparam logic [INV_W-1:0] INV_LIMIT_RST  = INV_W'(2);
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(4);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HR_LOW      = 3'd0,
        CFG_HR_HIGH     = 3'd1,
        CFG_SPO2_LOW    = 3'd2,
        CFG_MARGIN      = 3'd3,
        CFG_INV_LIMIT   = 3'd4,
        CFG_DECIM       = 3'd5
    } cfg_addr_t;

    // per-channel update request from the top level
    typedef struct packed {
        logic             step;
        logic             accept;
        logic [VAL_W-1:0] value;
    } chan_req_t;

endpackage

// ===== hw/rtl/vsos_decim.sv =====
// decimation phase counter, picks which items get processed
module vsos_decim (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [vsos_pkg::PERIOD_W-1:0] period,
    output logic                          process
);
    import vsos_pkg::*;

    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [PERIOD_W-1:0] period_eff;
    logic [PERIOD_W-1:0] phase_inc;

    assign process = (phase_reg == '0);

    always_comb begin
        if (period == '0) begin
            period_eff = PERIOD_W'(1);
        end else if (period > PERIOD_MAX) begin
            period_eff = PERIOD_MAX;
        end else begin
            period_eff = period;
        end
        phase_inc = {1'b0, phase_reg} + PERIOD_W'(1);
        if (!step) begin
            phase_next = phase_reg;
        end else if (phase_inc >= period_eff) begin
            phase_next = '0;
        end else begin
            phase_next = phase_inc[PHASE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== hw/rtl/vsos_chan.sv =====
// one channel: history, run counters, outlier check and windowed average
module vsos_chan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vsos_pkg::chan_req_t           req,
    input  logic                          check_high,
    input  logic [vsos_pkg::MARGIN_W-1:0] margin,
    input  logic [vsos_pkg::INV_W-1:0]    inv_limit,
    output logic [vsos_pkg::VAL_W-1:0]    avg_next
);
    import vsos_pkg::*;

    logic [VAL_W-1:0]  hist_reg [HIST_DEPTH];
    logic [VAL_W-1:0]  hist_next [HIST_DEPTH];
    logic [VAL_W-1:0]  hist_shift [HIST_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [INV_W-1:0]  inv_reg, inv_next;
    logic [VAL_W-1:0]  avg_reg;

    logic              keep;
    logic              drop;
    logic [VAL_W:0]    hi_bound;
    logic [VAL_W:0]    lo_bound;
    logic [VAL_W:0]    sum2 [8];
    logic [VAL_W+1:0]  sum4 [4];
    logic [VAL_W+2:0]  sum8 [2];
    logic [VAL_W+3:0]  sum16;

    // shifted history with the new reading at the top
    always_comb begin
        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
            hist_shift[i] = hist_reg[i+1];
        end
        hist_shift[HIST_DEPTH-1] = req.value;
    end

    // keep if the reading is under margin above (check_high) or under margin below any of the newest four entries
    always_comb begin
        keep = 1'b0;
        for (int i = HIST_DEPTH - 4; i < HIST_DEPTH; i++) begin
            hi_bound = {1'b0, hist_reg[i]} + {3'b000, margin};
            lo_bound = {1'b0, req.value} + {3'b000, margin};
            if (check_high) begin
                if ({1'b0, req.value} < hi_bound) begin
                    keep = 1'b1;
                end
            end else begin
                if (lo_bound > {1'b0, hist_reg[i]}) begin
                    keep = 1'b1;
                end
            end
        end
    end

    // adder tree over the shifted history
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            sum2[k] = {1'b0, hist_shift[2*k]} + {1'b0, hist_shift[2*k+1]};
        end
        for (int k = 0; k < 4; k++) begin
            sum4[k] = {1'b0, sum2[2*k]} + {1'b0, sum2[2*k+1]};
        end
        for (int k = 0; k < 2; k++) begin
            sum8[k] = {1'b0, sum4[2*k]} + {1'b0, sum4[2*k+1]};
        end
        sum16 = {1'b0, sum8[0]} + {1'b0, sum8[1]};
    end

    always_comb begin
        hist_next = hist_reg;
        fill_next = fill_reg;
        run_next  = run_reg;
        inv_next  = inv_reg;
        avg_next  = avg_reg;
        drop      = 1'b0;
        if (req.step) begin
            if (req.accept) begin
                inv_next = '0;
                if (run_reg >= RUN_FULL) begin
                    if (keep) begin
                        run_next = RUN_FULL;
                    end else begin
                        run_next = '0;
                        drop     = 1'b1;
                    end
                end else begin
                    run_next = run_reg + RUN_W'(1);
                end
                if (!drop) begin
                    hist_next = hist_shift;
                    if (fill_reg < FILL_W'(HIST_DEPTH)) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    if (fill_next < FILL_W'(2)) begin
                        avg_next = '0;
                    end else if (fill_next < FILL_W'(4)) begin
                        avg_next = sum2[7][VAL_W:1];
                    end else if (fill_next < FILL_W'(8)) begin
                        avg_next = sum4[3][VAL_W+1:2];
                    end else if (fill_next < FILL_W'(HIST_DEPTH)) begin
                        avg_next = sum8[1][VAL_W+2:3];
                    end else begin
                        avg_next = sum16[VAL_W+3:4];
                    end
                end
            end else begin
                run_next = '0;
                if (inv_reg >= inv_limit) begin
                    avg_next  = '0;
                    fill_next = '0;
                end else begin
                    inv_next = inv_reg + INV_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            fill_reg <= '0;
            run_reg  <= '0;
            inv_reg  <= '0;
            avg_reg  <= '0;
        end else begin
            hist_reg <= hist_next;
            fill_reg <= fill_next;
            run_reg  <= run_next;
            inv_reg  <= inv_next;
            avg_reg  <= avg_next;
        end
    end

`ifndef SYNTH
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(HIST_DEPTH))
        else $error("fill count past history depth");
    a_run_range: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= RUN_FULL)
        else $error("accept run past four");
    a_low_fill_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg < FILL_W'(2)) |-> (avg_reg == '0))
        else $error("average nonzero with fewer than two entries");
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !req.step |=> $stable(fill_reg) && $stable(avg_reg))
        else $error("channel state moved without a request");
`endif

endmodule

// ===== hw/rtl/vital_sign_outlier_smoother.sv =====
// top level: stream handshake, config registers, acceptance checks
//
// Smooths heart rate and SpO2 estimates with a windowed average and outlier
// rejection. One request on the s_ channel gives exactly one result on the
// m_ channel. Only one request in every decimation_period is processed; the
// rest return the current averages with updated low.
// Requests pass an input register, then compare, shift and a 16-entry
// adder tree into the result register that drives m_tvalid; one request is
// taken every cycle as long as the receiver keeps up. The input register
// is the only skid stage, so when m_tready is low a second request is
// still taken, then s_tready falls until the held result is taken.
// The config port (cfg_we, cfg_addr, cfg_wdata) writes one register per
// cycle; write only while no request is in flight.
// Reset (aresetn low, synchronous) clears both histories, fill and run
// counts, averages, the decimation phase and the handshake registers, and
// restores the default limits. No clearing pass follows reset.
module vital_sign_outlier_smoother (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // heart_rate[10:0], oxygen_level[21:11], zero fill
    input  logic [vsos_pkg::S_TDATA_W-1:0]  s_tdata,
    // heart_rate_ok[0], oxygen_level_ok[1]
    input  logic [vsos_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hr_average[9:0], spo2_average[19:10], zero fill
    output logic [vsos_pkg::M_TDATA_W-1:0]  m_tdata,
    // updated[0]
    output logic [vsos_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                            cfg_we,
    input  logic [vsos_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vsos_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import vsos_pkg::*;

    logic [VAL_W-1:0]    hr_low_reg, hr_high_reg, spo2_low_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [INV_W-1:0]    inv_limit_reg;
    logic [PERIOD_W-1:0] period_reg;

    logic                in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic [S_TUSER_W-1:0] in_user_reg;
    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;

    logic                advance;
    logic                process;
    logic [RAW_W-1:0]    hr_raw, sp_raw;
    logic                hr_ok, sp_ok;
    chan_req_t           hr_req, sp_req;
    logic [VAL_W-1:0]    hr_avg, sp_avg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign hr_raw = in_data_reg[RAW_W-1:0];
    assign sp_raw = in_data_reg[2*RAW_W-1:RAW_W];
    assign hr_ok  = in_user_reg[0];
    assign sp_ok  = in_user_reg[1];

    // negative raw values are never in range
    always_comb begin
        hr_req.step   = advance && process;
        hr_req.value  = hr_raw[VAL_W-1:0];
        hr_req.accept = hr_ok && !hr_raw[RAW_W-1]
                        && (hr_raw[VAL_W-1:0] > hr_low_reg)
                        && (hr_raw[VAL_W-1:0] < hr_high_reg);
        sp_req.step   = advance && process;
        sp_req.value  = sp_raw[VAL_W-1:0];
        sp_req.accept = sp_ok && !sp_raw[RAW_W-1]
                        && (sp_raw[VAL_W-1:0] > spo2_low_reg);
    end

    vsos_decim u_decim (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .period  (period_reg),
        .process (process)
    );

    vsos_chan u_hr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (hr_req),
        .check_high (1'b1),
        .margin     (margin_reg),
        .inv_limit  (inv_limit_reg),
        .avg_next   (hr_avg)
    );

    vsos_chan u_spo2 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (sp_req),
        .check_high (1'b0),
        .margin     (margin_reg),
        .inv_limit  (inv_limit_reg),
        .avg_next   (sp_avg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hr_low_reg    <= HR_LOW_RST;
            hr_high_reg   <= HR_HIGH_RST;
            spo2_low_reg  <= SPO2_LOW_RST;
            margin_reg    <= MARGIN_RST;
            inv_limit_reg <= INV_LIMIT_RST;
            period_reg    <= PERIOD_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_HR_LOW:    hr_low_reg    <= cfg_wdata[VAL_W-1:0];
                CFG_HR_HIGH:   hr_high_reg   <= cfg_wdata[VAL_W-1:0];
                CFG_SPO2_LOW:  spo2_low_reg  <= cfg_wdata[VAL_W-1:0];
                CFG_MARGIN:    margin_reg    <= cfg_wdata[MARGIN_W-1:0];
                CFG_INV_LIMIT: inv_limit_reg <= cfg_wdata[INV_W-1:0];
                CFG_DECIM:     period_reg    <= cfg_wdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (advance) begin
            out_data_reg <= {(M_TDATA_W - 2*VAL_W)'(0), sp_avg, hr_avg};
            out_user_reg <= process;
        end
    end

`ifndef SYNTH
    a_fill_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("pending request not moved to empty result register");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("request taken while both stages are full and stalled");
`endif

endmodule

// ===== verif/vital_sign_outlier_smoother_tb.sv =====
// testbench for the vital sign outlier smoother: directed rows, then random phases
module vital_sign_outlier_smoother_tb;
    import vsos_pkg::*;

    localparam int RANDOM_TARGET = 1250;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_PHASE    = 5;
    localparam int REGROUP_ROW   = 5;
    localparam int CH_HR         = 0;
    localparam int CH_SPO2       = 1;
    localparam int VAL_MAX       = 1023;

    typedef struct packed {
        logic             updated;
        logic [VAL_W-1:0] spo2_avg;
        logic [VAL_W-1:0] hr_avg;
    } smooth_out_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] hr;
        logic                    hr_ok;
        logic signed [RAW_W-1:0] sp;
        logic                    sp_ok;
        logic                    typed;
        logic [VAL_W-1:0]        hr_avg;
        logic [VAL_W-1:0]        spo2_avg;
        logic                    updated;
    } reading_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    vital_sign_outlier_smoother uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // smoother state as the block should hold it
    logic [VAL_W-1:0] hist [2][HIST_DEPTH];
    int               fill [2];
    int               accept_run [2];
    int               invalid_run [2];
    logic [VAL_W-1:0] avg [2];
    int               decim_phase;
    int lim_hr_lo, lim_hr_hi, lim_sp_lo, lim_margin, lim_invalid, lim_period;

    smooth_out_t results_due [$];
    int readings_sent = 0, readings_used = 0, outliers_dropped = 0;
    int results_checked = 0, errors = 0, settings_applied = 0, cycle_count = 0;
    bit tx_idling = 1'b0, rx_idling = 1'b0;
    int rx_stall = 0, rx_hold_req = 0;

    reading_row_t directed_rows [19] = '{
        '{100, 1, 95, 1, 1, 0, 0, 1},           // one entry only: no average yet
        '{-1024, 1, -1024, 1, 1, 0, 0, 0},
        '{1023, 1, 1023, 1, 1, 0, 0, 0},
        '{0, 0, 0, 0, 1, 0, 0, 0},
        '{102, 1, 97, 1, 1, 101, 96, 1},
        '{0, 0, 0, 0, 1, 101, 96, 0},           // phase left over from period 4
        '{60, 1, 80, 1, 0, 0, 0, 0},            // equal to the limits
        '{150, 1, -1, 1, 0, 0, 0, 0},
        '{61, 0, 81, 0, 1, 0, 0, 1},            // invalid run hits limit: cleared
        '{70, 1, 95, 1, 0, 0, 0, 0},
        '{72, 1, 96, 1, 0, 0, 0, 0},
        '{71, 1, 97, 1, 0, 0, 0, 0},
        '{73, 1, 96, 1, 0, 0, 0, 0},
        '{90, 1, 81, 1, 0, 0, 0, 0},            // both channels out of margin
        '{74, 1, 1023, 1, 0, 0, 0, 0},
        '{-1, 1, -1024, 0, 0, 0, 0, 0},
        '{1023, 0, 512, 1, 0, 0, 0, 0},
        '{149, 1, 100, 1, 0, 0, 0, 0},
        '{-1024, 0, 1023, 1, 0, 0, 0, 0}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void smoother_reset();
        for (int ch = 0; ch < 2; ch++) begin
            for (int i = 0; i < HIST_DEPTH; i++)
                hist[ch][i] = '0;
            fill[ch] = 0;
            accept_run[ch] = 0;
            invalid_run[ch] = 0;
            avg[ch] = '0;
        end
        decim_phase = 0;
        lim_hr_lo   = int'(HR_LOW_RST);
        lim_hr_hi   = int'(HR_HIGH_RST);
        lim_sp_lo   = int'(SPO2_LOW_RST);
        lim_margin  = int'(MARGIN_RST);
        lim_invalid = int'(INV_LIMIT_RST);
        lim_period  = int'(PERIOD_RST);
    endfunction

    function automatic void channel_take(int ch, int v);
        bit keep;
        int sum;
        int n;
        keep = 1'b0;
        sum = 0;
        invalid_run[ch] = 0;
        if (accept_run[ch] >= 4) begin
            // kept if the reading is under the margin above (heart rate) or below (SpO2) any of the four newest entries
            for (int i = HIST_DEPTH - 4; i < HIST_DEPTH; i++) begin
                if (ch == CH_HR ? (v < int'(hist[ch][i]) + lim_margin)
                                : (v + lim_margin > int'(hist[ch][i])))
                    keep = 1'b1;
            end
            if (!keep) begin
                accept_run[ch] = 0;
                outliers_dropped++;
                return;
            end
        end else begin
            accept_run[ch]++;
        end
        for (int i = 0; i < HIST_DEPTH - 1; i++)
            hist[ch][i] = hist[ch][i + 1];
        hist[ch][HIST_DEPTH - 1] = v[VAL_W-1:0];
        if (fill[ch] < HIST_DEPTH)
            fill[ch]++;
        if (fill[ch] < 2) begin
            avg[ch] = '0;
            return;
        end
        n = (fill[ch] < 4) ? 2 : (fill[ch] < 8) ? 4 : (fill[ch] < 16) ? 8 : 16;
        for (int i = HIST_DEPTH - n; i < HIST_DEPTH; i++)
            sum += int'(hist[ch][i]);
        avg[ch] = VAL_W'(sum >> $clog2(n));
    endfunction

    function automatic void channel_refuse(int ch);
        accept_run[ch] = 0;
        if (invalid_run[ch] >= lim_invalid) begin
            avg[ch] = '0;
            fill[ch] = 0;
        end else begin
            invalid_run[ch] = (invalid_run[ch] + 1) & 3;
        end
    endfunction

    function automatic smooth_out_t smoother_step(logic signed [RAW_W-1:0] hr, logic hr_ok,
                                                  logic signed [RAW_W-1:0] sp, logic sp_ok);
        smooth_out_t r;
        int period;
        bit take;
        int hr_v;
        int sp_v;
        period = lim_period;
        if (period < 1)
            period = 1;
        if (period > 8)
            period = 8;
        take = (decim_phase == 0);
        decim_phase = (decim_phase + 1 >= period) ? 0 : ((decim_phase + 1) & 7);
        hr_v = int'(hr);
        sp_v = int'(sp);
        if (take) begin
            if (hr_ok && hr_v > lim_hr_lo && hr_v < lim_hr_hi)
                channel_take(CH_HR, hr_v);
            else
                channel_refuse(CH_HR);
            if (sp_ok && sp_v > lim_sp_lo)
                channel_take(CH_SPO2, sp_v);
            else
                channel_refuse(CH_SPO2);
        end
        r.hr_avg = avg[CH_HR];
        r.spo2_avg = avg[CH_SPO2];
        r.updated = take;
        return r;
    endfunction

    function automatic int window_lo(int ch);
        return (ch == CH_HR) ? lim_hr_lo + 1 : lim_sp_lo + 1;
    endfunction

    function automatic int window_hi(int ch);
        return (ch == CH_HR) ? lim_hr_hi - 1 : VAL_MAX;
    endfunction

    function automatic int window_center(int ch);
        int lo;
        int hi;
        lo = window_lo(ch);
        hi = window_hi(ch);
        return (lo <= hi) ? int'($urandom_range(hi, lo)) : 0;
    endfunction

    // mostly steady readings around a center, some spikes, dropouts and noise
    function automatic void pick_reading(input int ch, input int center,
                                         output logic signed [RAW_W-1:0] raw, output logic ok);
        int lo;
        int hi;
        int v;
        int r;
        int jit;
        lo = window_lo(ch);
        hi = window_hi(ch);
        r = $urandom_range(0, 99);
        jit = $urandom_range(0, 6);
        ok = 1'b1;
        if (r < 82 && lo <= hi) begin
            if (r < 72)
                v = center - jit + int'($urandom_range(0, 2 * jit));
            else if (ch == CH_HR)
                v = center + lim_margin + int'($urandom_range(40, jit));
            else
                v = center - lim_margin - int'($urandom_range(40, jit));
            if (v < lo)
                v = lo;
            if (v > hi)
                v = hi;
        end else begin
            v = int'($urandom_range(0, 2047)) - 1024;
            ok = (r < 91) ? 1'b0 : 1'($urandom_range(0, 1));
        end
        raw = RAW_W'(v);
    endfunction

    task automatic reg_write(cfg_addr_t a, int d);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= CFG_DATA_W'(d);
        @(posedge aclk);
        case (a)
            CFG_HR_LOW:    lim_hr_lo = d & 'h3FF;
            CFG_HR_HIGH:   lim_hr_hi = d & 'h3FF;
            CFG_SPO2_LOW:  lim_sp_lo = d & 'h3FF;
            CFG_MARGIN:    lim_margin = d & 'hFF;
            CFG_INV_LIMIT: lim_invalid = d & 'h3;
            CFG_DECIM:     lim_period = d & 'hF;
            default: ;
        endcase
    endtask

    task automatic program_limits(int hr_lo, int hr_hi, int sp_lo, int margin,
                                  int inv_lim, int period);
        reg_write(CFG_HR_LOW, hr_lo);
        reg_write(CFG_HR_HIGH, hr_hi);
        reg_write(CFG_SPO2_LOW, sp_lo);
        reg_write(CFG_MARGIN, margin);
        reg_write(CFG_INV_LIMIT, inv_lim);
        reg_write(CFG_DECIM, period);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_reading(input logic signed [RAW_W-1:0] hr, input logic hr_ok,
                                input logic signed [RAW_W-1:0] sp, input logic sp_ok,
                                input logic typed, input smooth_out_t typed_out);
        smooth_out_t predicted;
        int gap;
        if (tx_idling && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'({sp, hr});
        s_tuser <= {sp_ok, hr_ok};
        do
            @(posedge aclk);
        while (!s_tready);
        predicted = smoother_step(hr, hr_ok, sp, sp_ok);
        results_due.push_back(typed ? typed_out : predicted);
        readings_sent++;
        if (predicted.updated)
            readings_used++;
    endtask

    // receiver: random stall bursts, or one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_hold_req != 0) begin
                rx_stall = rx_hold_req;
                rx_hold_req = 0;
            end else if (rx_stall == 0 && rx_idling && $urandom_range(0, 9) == 0) begin
                rx_stall = $urandom_range(1, 19);
            end
            if (rx_stall != 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        smooth_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result hr_avg %0d spo2_avg %0d updated %0b",
                         $time, m_tdata[9:0], m_tdata[19:10], m_tuser[0]);
                errors++;
            end else begin
                want = results_due.pop_front();
                results_checked++;
                if (m_tdata[9:0] !== want.hr_avg) begin
                    $display("%0t: hr_average expected %0d actual %0d",
                             $time, want.hr_avg, m_tdata[9:0]);
                    errors++;
                end
                if (m_tdata[19:10] !== want.spo2_avg) begin
                    $display("%0t: spo2_average expected %0d actual %0d",
                             $time, want.spo2_avg, m_tdata[19:10]);
                    errors++;
                end
                if (m_tuser[0] !== want.updated) begin
                    $display("%0t: updated expected %0b actual %0b",
                             $time, want.updated, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, results_due.size());
        $display("vital_sign_outlier_smoother_tb failed");
        $finish;
    end

    initial begin
        smooth_out_t typed_out;
        logic signed [RAW_W-1:0] hr;
        logic signed [RAW_W-1:0] sp;
        logic hr_ok;
        logic sp_ok;
        int hr_center;
        int sp_center;
        int n_items;
        int phase_no;
        int hr_lo;
        bit final_stretch;
        smoother_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part: defaults after reset first, then period 1
        for (int i = 0; i < 19; i++) begin
            if (i == REGROUP_ROW) begin
                wait_idle();
                program_limits(int'(HR_LOW_RST), int'(HR_HIGH_RST), int'(SPO2_LOW_RST),
                               int'(MARGIN_RST), int'(INV_LIMIT_RST), 1);
            end
            typed_out.hr_avg = directed_rows[i].hr_avg;
            typed_out.spo2_avg = directed_rows[i].spo2_avg;
            typed_out.updated = directed_rows[i].updated;
            send_reading(directed_rows[i].hr, directed_rows[i].hr_ok, directed_rows[i].sp,
                         directed_rows[i].sp_ok, directed_rows[i].typed, typed_out);
        end

        phase_no = 0;
        while (readings_sent < RANDOM_TARGET) begin
            wait_idle();
            case (phase_no)
                0: program_limits(int'(HR_LOW_RST), int'(HR_HIGH_RST), int'(SPO2_LOW_RST),
                                  int'(MARGIN_RST), int'(INV_LIMIT_RST), int'(PERIOD_RST));
                1: program_limits(0, VAL_MAX, 0, 0, 0, 1);
                2: program_limits(VAL_MAX, VAL_MAX, VAL_MAX, 255, 3, 15);
                3: program_limits(40, 200, 50, 255, 3, 0);
                4: program_limits(100, 102, 90, 1, 1, 2);
                default: begin
                    hr_lo = $urandom_range(0, 300);
                    program_limits(hr_lo, hr_lo + int'($urandom_range(2, 500)),
                                   $urandom_range(0, 900),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 30),
                                   $urandom_range(0, 3),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(1, 3));
                end
            endcase
            hr_center = window_center(CH_HR);
            sp_center = window_center(CH_SPO2);
            final_stretch = readings_sent >= RANDOM_TARGET * 4 / 5;
            tx_idling = !final_stretch && $urandom_range(0, 3) != 0;
            rx_idling = !final_stretch && $urandom_range(0, 3) != 0;
            if (phase_no == HOLD_PHASE) begin
                // sender keeps offering while the receiver holds off
                tx_idling = 1'b0;
                rx_hold_req = LONG_HOLD;
            end
            n_items = $urandom_range(60, 140);
            for (int k = 0; k < n_items; k++) begin
                pick_reading(CH_HR, hr_center, hr, hr_ok);
                pick_reading(CH_SPO2, sp_center, sp, sp_ok);
                send_reading(hr, hr_ok, sp, sp_ok, 1'b0, '0);
            end
            phase_no++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d requests, %0d processed, %0d outliers dropped, %0d settings",
                 readings_sent, readings_used, outliers_dropped, settings_applied);
        $display("checked %0d results with %0d mismatches", results_checked, errors);
        if (errors == 0 && results_due.size() == 0)
            $display("vital_sign_outlier_smoother_tb passed");
        else
            $display("vital_sign_outlier_smoother_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/vsos_pkg.sv
hw/rtl/vsos_decim.sv
hw/rtl/vsos_chan.sv
hw/rtl/vital_sign_outlier_smoother.sv
verif/vital_sign_outlier_smoother_tb.sv
